[rtl/triangle_center_normal_area_macros.svh]
// Assertion macros for the triangle center, normal and area block.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef TRIANGLE_CENTER_NORMAL_AREA_MACROS_SVH
`define TRIANGLE_CENTER_NORMAL_AREA_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TCNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcna: check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TCNA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcna: check failed");

`endif

[rtl/tcna_pkg.sv]
// Package for the triangle center, normal and area block: widths, word types.
// Used by every other file of the block except the macro header; depends on nothing.
`timescale 1ns / 1ps

package tcna_pkg;

  // Coordinate format and the widths that follow from it.
  localparam int unsigned CoordW    = 32;
  localparam int unsigned EdgeW     = CoordW + 1;
  localparam int unsigned SumW      = CoordW + 2;
  localparam int unsigned ProdW     = 2 * EdgeW;
  localparam int unsigned CrossW    = ProdW;
  localparam int unsigned MagW      = CrossW - 1;
  localparam int unsigned LoW       = EdgeW;
  localparam int unsigned HiW       = MagW - LoW;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned NormSumW  = SqW + 2;

  // Rounded mean of three by reciprocal multiplication.
  localparam int unsigned MeanW     = SumW - 1;
  localparam int unsigned RecipK    = MeanW + 2;
  localparam int unsigned MeanProdW = 2 * MeanW + 1;
  localparam logic [MeanW:0] Recip3 =
    (MeanW + 1)'(((64'd1 << RecipK) + 64'd2) / 64'd3);

  // Output formats.
  localparam int unsigned NormW     = 32;
  localparam int unsigned NormFrac  = NormW - 2;
  localparam int unsigned AreaW     = 64;

  // Normal lane: quotient of square over sum, then its square root.
  localparam int unsigned QuotW       = 2 * NormFrac + 3;
  localparam int unsigned DivSteps    = QuotW;
  localparam int unsigned DivRemW     = NormSumW + 1;
  localparam int unsigned QRadW       = QuotW + 1;
  localparam int unsigned QRootW      = QRadW / 2;
  localparam int unsigned QRemW       = QRootW + 4;
  localparam int unsigned QSqrtSteps  = QRootW;
  localparam int unsigned LaneDepth   = DivSteps + QSqrtSteps;

  // Area: square root of the squared cross-product length.
  localparam int unsigned ARootW      = NormSumW / 2;
  localparam int unsigned ARemW       = ARootW + 4;
  localparam int unsigned ASqrtSteps  = ARootW;
  localparam int unsigned ADelay      = LaneDepth - ASqrtSteps;

  localparam int unsigned FrontDepth  = 7;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } tcna_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic [AreaW-1:0]         area;
    logic                     degenerate;
  } tcna_out_t;

  // Front end to the back end: squared components, their sum, signs, centroid.
  typedef struct packed {
    logic [2:0][SqW-1:0]    sq;
    logic [NormSumW-1:0]    s;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] center;
  } tcna_front_t;

  // One normal lane's result.
  typedef struct packed {
    logic [QRootW-1:0] root;
    logic              neg;
  } tcna_lane_t;

  // Area path result with the words that travel beside it.
  typedef struct packed {
    logic [AreaW-1:0]       area;
    logic                   degen;
    logic [2:0][CoordW-1:0] center;
  } tcna_area_t;

endpackage

[rtl/tcna_if.sv]
// Valid/ready channel interfaces for triangle words in and result words out.
// Depends on tcna_pkg for the payload types.
`timescale 1ns / 1ps

interface tcna_in_if
  import tcna_pkg::*;
();
  logic     valid;
  logic     ready;
  tcna_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcna_out_if
  import tcna_pkg::*;
();
  logic      valid;
  logic      ready;
  tcna_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/tcna_front.sv]
// Front end: edges, centroid, cross product, squared components and their sum.
// Seven register stages; depends on tcna_pkg.
`timescale 1ns / 1ps

module tcna_front
  import tcna_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  tcna_in_t    data_i,
  output logic        valid_o,
  output tcna_front_t data_o
);

  logic signed [CoordW-1:0] va [3];
  logic signed [CoordW-1:0] vb [3];
  logic signed [CoordW-1:0] vc [3];

  assign va[0] = data_i.ax;
  assign va[1] = data_i.ay;
  assign va[2] = data_i.az;
  assign vb[0] = data_i.bx;
  assign vb[1] = data_i.by_coord;
  assign vb[2] = data_i.bz;
  assign vc[0] = data_i.cx;
  assign vc[1] = data_i.cy;
  assign vc[2] = data_i.cz;

  logic [FrontDepth-1:0] valid_q;

  logic signed [EdgeW-1:0]  e1_q [3], e1_d [3], e2_q [3], e2_d [3];
  logic signed [SumW-1:0]   sum_q [3], sum_d [3];
  logic signed [ProdW-1:0]  pa_q [3], pa_d [3], pb_q [3], pb_d [3];
  logic [MeanW-1:0]         mag_q [3], mag_d [3];
  logic [2:0]               msgn2_q, msgn2_d, msgn3_q;
  logic signed [CrossW-1:0] x_q [3], x_d [3];
  logic [MeanProdW-1:0]     mp_q [3], mp_d [3];
  logic [MagW-1:0]          xmag_q [3], xmag_d [3];
  logic [2:0]               neg4_q, neg4_d, neg5_q, neg6_q, neg7_q;
  logic [2:0][CoordW-1:0]   center4_q, center4_d, center5_q, center6_q, center7_q;
  logic [2*HiW-1:0]         hh_q [3], hh_d [3];
  logic [HiW+LoW-1:0]       hl_q [3], hl_d [3];
  logic [2*LoW-1:0]         ll_q [3], ll_d [3];
  logic [SqW-1:0]           sq6_q [3], sq6_d [3], sq7_q [3];
  logic [NormSumW-1:0]      s7_q, s7_d;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    localparam int K1 = (j + 1) % 3;
    localparam int K2 = (j + 2) % 3;
    logic [CoordW-1:0] cq;
    logic [HiW-1:0]    hi;
    logic [LoW-1:0]    lo;

    // Edge vectors and coordinate sum.
    assign e1_d[j]  = {vc[j][CoordW-1], vc[j]} - {va[j][CoordW-1], va[j]};
    assign e2_d[j]  = {vb[j][CoordW-1], vb[j]} - {va[j][CoordW-1], va[j]};
    assign sum_d[j] = {{2{va[j][CoordW-1]}}, va[j]} + {{2{vb[j][CoordW-1]}}, vb[j]}
                    + {{2{vc[j][CoordW-1]}}, vc[j]};

    // Cross-product partial products; magnitude of the sum plus one.
    assign pa_d[j]    = e1_q[K1] * e2_q[K2];
    assign pb_d[j]    = e1_q[K2] * e2_q[K1];
    assign msgn2_d[j] = sum_q[j][SumW-1];
    assign mag_d[j]   = sum_q[j][SumW-1] ? MeanW'(~sum_q[j] + SumW'(2))
                                         : MeanW'(sum_q[j] + SumW'(1));

    // Cross-product component; division by three as a reciprocal product.
    assign x_d[j]  = pa_q[j] - pb_q[j];
    assign mp_d[j] = MeanProdW'(mag_q[j]) * MeanProdW'(Recip3);

    // Component magnitude and sign; signed centroid.
    assign neg4_d[j]    = x_q[j][CrossW-1];
    assign xmag_d[j]    = x_q[j][CrossW-1] ? MagW'(-x_q[j]) : MagW'(x_q[j]);
    assign cq           = mp_q[j][RecipK +: CoordW];
    assign center4_d[j] = msgn3_q[j] ? (~cq + CoordW'(1)) : cq;

    // Square of the magnitude as three narrow products.
    assign hi       = xmag_q[j][MagW-1 -: HiW];
    assign lo       = xmag_q[j][LoW-1:0];
    assign hh_d[j]  = (2*HiW)'(hi) * (2*HiW)'(hi);
    assign hl_d[j]  = (HiW+LoW)'(hi) * (HiW+LoW)'(lo);
    assign ll_d[j]  = (2*LoW)'(lo) * (2*LoW)'(lo);
    assign sq6_d[j] = (SqW'(hh_q[j]) << (2*LoW)) + (SqW'(hl_q[j]) << (LoW+1))
                    + SqW'(ll_q[j]);

    assign data_o.sq[j] = sq7_q[j];
  end

  // Squared length of the cross product.
  assign s7_d = NormSumW'(sq6_q[0]) + NormSumW'(sq6_q[1]) + NormSumW'(sq6_q[2]);

  // Payload registers of all seven stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        e1_q[j]   <= e1_d[j];
        e2_q[j]   <= e2_d[j];
        sum_q[j]  <= sum_d[j];
        pa_q[j]   <= pa_d[j];
        pb_q[j]   <= pb_d[j];
        mag_q[j]  <= mag_d[j];
        x_q[j]    <= x_d[j];
        mp_q[j]   <= mp_d[j];
        xmag_q[j] <= xmag_d[j];
        hh_q[j]   <= hh_d[j];
        hl_q[j]   <= hl_d[j];
        ll_q[j]   <= ll_d[j];
        sq6_q[j]  <= sq6_d[j];
        sq7_q[j]  <= sq6_q[j];
      end
      msgn2_q   <= msgn2_d;
      msgn3_q   <= msgn2_q;
      neg4_q    <= neg4_d;
      neg5_q    <= neg4_q;
      neg6_q    <= neg5_q;
      neg7_q    <= neg6_q;
      center4_q <= center4_d;
      center5_q <= center4_q;
      center6_q <= center5_q;
      center7_q <= center6_q;
      s7_q      <= s7_d;
    end
  end

  // Valid bits travel beside the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[FrontDepth-2:0], valid_i};
    end
  end

  assign valid_o       = valid_q[FrontDepth-1];
  assign data_o.s      = s7_q;
  assign data_o.neg    = neg7_q;
  assign data_o.center = center7_q;

endmodule

[rtl/tcna_norm_lane.sv]
// One normal component: pipelined restoring divide of the scaled square by the
// squared length, then a pipelined integer square root. Depends on tcna_pkg.
`timescale 1ns / 1ps

module tcna_norm_lane
  import tcna_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SqW-1:0]      sq_i,
  input  logic [NormSumW-1:0] s_i,
  input  logic                neg_i,
  output tcna_lane_t          res_o
);

  logic [DivRemW-1:0]  rem_q [DivSteps-1];
  logic [NormSumW-1:0] den_q [DivSteps-1];
  logic [QuotW-1:0]    quo_q [DivSteps];
  logic [QRadW-1:0]    rad_q [QSqrtSteps-1];
  logic [QRemW-1:0]    qrem_q [QSqrtSteps-1];
  logic [QRootW-1:0]   root_q [QSqrtSteps];
  logic [LaneDepth-1:0] neg_q;

  // Divider: one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [DivRemW-1:0]  rin, rem_d;
    logic [NormSumW-1:0] din;
    logic [QuotW-1:0]    qin, quo_d;
    logic                ge;

    if (k == 0) begin : g_first
      assign rin = DivRemW'(sq_i);
      assign din = s_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = {rem_q[k-1][DivRemW-2:0], 1'b0};
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end

    assign ge    = rin >= DivRemW'(din);
    assign rem_d = ge ? (rin - DivRemW'(din)) : rin;
    assign quo_d = {qin[QuotW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_d;
      end
    end

    if (k < DivSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          den_q[k] <= din;
        end
      end
    end
  end

  // Square root of the quotient: one root bit per stage.
  for (genvar m = 0; m < QSqrtSteps; m++) begin : g_sqrt
    logic [QRadW-1:0]  rad_in;
    logic [QRemW-1:0]  rem_in, r2, trial, rem_d;
    logic [QRootW-1:0] root_in, root_d;
    logic              ge;

    if (m == 0) begin : g_first
      assign rad_in  = {1'b0, quo_q[DivSteps-1]};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[m-1];
      assign rem_in  = qrem_q[m-1];
      assign root_in = root_q[m-1];
    end

    assign r2     = {rem_in[QRemW-3:0], rad_in[QRadW-1 -: 2]};
    assign trial  = QRemW'({root_in, 2'b01});
    assign ge     = r2 >= trial;
    assign rem_d  = ge ? (r2 - trial) : r2;
    assign root_d = {root_in[QRootW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[m] <= root_d;
      end
    end

    if (m < QSqrtSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[m]  <= rad_in << 2;
          qrem_q[m] <= rem_d;
        end
      end
    end
  end

  // Sign of the component rides along with the lane.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= {neg_q[LaneDepth-2:0], neg_i};
    end
  end

  assign res_o.root = root_q[QSqrtSteps-1];
  assign res_o.neg  = neg_q[LaneDepth-1];

endmodule

[rtl/tcna_area.sv]
// Area path: pipelined square root of the squared length, rounding and
// saturation, plus the valid bits, centroid and degenerate flag. Uses tcna_pkg.
`timescale 1ns / 1ps

module tcna_area
  import tcna_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [NormSumW-1:0]    s_i,
  input  logic [2:0][CoordW-1:0] center_i,
  output logic                   valid_o,
  output tcna_area_t             res_o
);

  logic [LaneDepth-1:0]   valid_q;
  logic [LaneDepth-1:0]   degen_q;
  logic [2:0][CoordW-1:0] center_q [LaneDepth];
  logic [NormSumW-1:0]    rad_q [ASqrtSteps-1];
  logic [ARemW-1:0]       rem_q [ASqrtSteps-1];
  logic [ARootW-1:0]      root_q [ASqrtSteps];
  logic [AreaW-1:0]       area_q [ADelay];
  logic [AreaW-1:0]       area_d;
  logic [ARootW:0]        rnd;

  // Square root of the squared length: one root bit per stage.
  for (genvar m = 0; m < ASqrtSteps; m++) begin : g_sqrt
    logic [NormSumW-1:0] rad_in;
    logic [ARemW-1:0]    rem_in, r2, trial, rem_d;
    logic [ARootW-1:0]   root_in, root_d;
    logic                ge;

    if (m == 0) begin : g_first
      assign rad_in  = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[m-1];
      assign rem_in  = rem_q[m-1];
      assign root_in = root_q[m-1];
    end

    assign r2     = {rem_in[ARemW-3:0], rad_in[NormSumW-1 -: 2]};
    assign trial  = ARemW'({root_in, 2'b01});
    assign ge     = r2 >= trial;
    assign rem_d  = ge ? (r2 - trial) : r2;
    assign root_d = {root_in[ARootW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[m] <= root_d;
      end
    end

    if (m < ASqrtSteps - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[m] <= rad_in << 2;
          rem_q[m] <= rem_d;
        end
      end
    end
  end

  // Half the length, rounded up on a tie, clamped to all ones.
  assign rnd    = {1'b0, root_q[ASqrtSteps-1]} + (ARootW+1)'(1);
  assign area_d = (|rnd[ARootW:AreaW+1]) ? '1 : rnd[AreaW:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      area_q[0] <= area_d;
      for (int d = 1; d < ADelay; d++) begin
        area_q[d] <= area_q[d-1];
      end
      center_q[0] <= center_i;
      for (int d = 1; d < LaneDepth; d++) begin
        center_q[d] <= center_q[d-1];
      end
      degen_q <= {degen_q[LaneDepth-2:0], s_i == '0};
    end
  end

  // Valid bits travel beside the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[LaneDepth-2:0], valid_i};
    end
  end

  assign valid_o      = valid_q[LaneDepth-1];
  assign res_o.area   = area_q[ADelay-1];
  assign res_o.degen  = degen_q[LaneDepth-1];
  assign res_o.center = center_q[LaneDepth-1];

endmodule

[rtl/triangle_center_normal_area.sv]
// Triangle centroid, unit normal and area. One triangle word is accepted in
// every cycle and its result word passes through, in order, one input
// register, six front-end stages for edges, cross product and its squared
// length, 95 stages in each normal lane (a 63-stage restoring divider followed
// by a 32-stage square root, one bit per stage) with the 66-stage area square
// root alongside, and one output register. A skid register behind the output
// lets the pipeline advance once while a result waits; the input stalls only
// while that skid register is full. The block holds no state beyond the
// pipeline and needs no clearing after reset.
`timescale 1ns / 1ps

module triangle_center_normal_area
  import tcna_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tcna_in_if.sink    in_i,
  tcna_out_if.source out_o
);

  logic        en;
  logic        front_valid, area_valid;
  tcna_front_t front;
  tcna_area_t  area_res;
  tcna_lane_t  lane_res [3];
  logic [NormW-1:0] normal [3];

  logic      out_v_q, skid_v_q;
  tcna_out_t out_q, out_d, skid_q;

  // The whole pipeline advances unless the skid register holds a word.
  assign en        = !skid_v_q;
  assign in_i.ready = en;

  tcna_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (front_valid),
    .data_o  (front)
  );

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [QRootW:0] rnd;
    logic [NormW-1:0] nq;

    tcna_norm_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (front.sq[j]),
      .s_i   (front.s),
      .neg_i (front.neg[j]),
      .res_o (lane_res[j])
    );

    // Round the root to the normal magnitude and point it against the cross.
    assign rnd       = {1'b0, lane_res[j].root} + (QRootW+1)'(1);
    assign nq        = NormW'(rnd[QRootW:1]);
    assign normal[j] = area_res.degen ? '0 : (lane_res[j].neg ? nq : (~nq + NormW'(1)));
  end

  tcna_area u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (front_valid),
    .s_i      (front.s),
    .center_i (front.center),
    .valid_o  (area_valid),
    .res_o    (area_res)
  );

  // Assemble the result word.
  always_comb begin
    out_d.center_x   = area_res.center[0];
    out_d.center_y   = area_res.center[1];
    out_d.center_z   = area_res.center[2];
    out_d.normal_x   = normal[0];
    out_d.normal_y   = normal[1];
    out_d.normal_z   = normal[2];
    out_d.area       = area_res.area;
    out_d.degenerate = area_res.degen;
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
      if (out_v_q && !out_o.ready) begin
        skid_q <= out_q;
      end
    end
  end

  // Output and skid valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      out_v_q  <= area_valid;
      skid_v_q <= out_v_q && !out_o.ready;
    end else if (out_o.ready) begin
      skid_v_q <= 1'b0;
    end
  end

  assign out_o.valid = out_v_q || skid_v_q;
  assign out_o.data  = skid_v_q ? skid_q : out_q;

endmodule

[rtl/tcna_checker.sv]
// Port checker for the triangle center, normal and area block, bound to the top.
// Depends on tcna_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "triangle_center_normal_area_macros.svh"

module tcna_checker
  import tcna_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input tcna_out_t out_data_i
);

  // A result word that is not taken stays and holds its value.
  `TCNA_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // A degenerate triangle gives a zero normal and a zero area.
  `TCNA_ASSERT_IMP(a_degen_zero, out_valid_i && out_data_i.degenerate, out_data_i.normal_x == 0 && out_data_i.normal_y == 0 && out_data_i.normal_z == 0 && out_data_i.area == 0)

  // Any other triangle has a normal with at least one nonzero component.
  `TCNA_ASSERT_IMP(a_normal_set, out_valid_i && !out_data_i.degenerate, out_data_i.normal_x != 0 || out_data_i.normal_y != 0 || out_data_i.normal_z != 0)

  // The input stalls only while a result word waits at the output.
  `TCNA_ASSERT_IMP(a_stall_cause, in_valid_i && !in_ready_i, out_valid_i)

endmodule

bind triangle_center_normal_area tcna_checker u_tcna_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

[tb/triangle_center_normal_area_tb.sv]
// Testbench for triangle_center_normal_area: centroid, unit normal and area.
// Drives triangle words, predicts each result word with exact wide arithmetic
// and checks it. Depends on tcna_pkg, tcna_if and the block itself.
`timescale 1ns / 1ps

module triangle_center_normal_area_tb;
  import tcna_pkg::*;

  localparam int          ClkHalf     = 5;
  localparam int          ResetCycles = 9;
  localparam int          Latency     = 103;
  localparam int          StallLimit  = 20000;
  localparam int          RandItems   = 380;
  localparam int signed   CoordMax    = 32'sh7fffffff;
  localparam int signed   CoordMin    = -32'sh7fffffff - 1;

  logic clk_i;
  logic rst_ni;

  tcna_in_if  in_if ();
  tcna_out_if out_if ();

  triangle_center_normal_area u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tcna_out_t pending_results[$];
  int        error_count;
  int        send_idle_pct;
  int        stall_pct;
  int        quiet_cycles;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Rounded mean of three coordinates, ties cannot occur.
  function automatic logic [31:0] mean_of_three(longint signed total);
    if (total >= 0) return 32'((total + 1) / 3);
    return 32'(-((-total + 1) / 3));
  endfunction

  // Exact centroid, unit normal and area of one triangle.
  function automatic tcna_out_t triangle_result(tcna_in_t t);
    tcna_out_t        r;
    longint signed    v[9];
    logic signed [67:0] e1[3], e2[3], cr[3];
    logic [255:0]     sq[3], len_sq, rhs, lhs, d, mag;
    logic [31:0]      nq, cand;
    logic [63:0]      area, acand;
    logic             degen;
    int               j, k1, k2, b;
    v[0] = t.ax; v[1] = t.ay; v[2] = t.az;
    v[3] = t.bx; v[4] = t.by_coord; v[5] = t.bz;
    v[6] = t.cx; v[7] = t.cy; v[8] = t.cz;
    r.center_x = mean_of_three(v[0] + v[3] + v[6]);
    r.center_y = mean_of_three(v[1] + v[4] + v[7]);
    r.center_z = mean_of_three(v[2] + v[5] + v[8]);
    for (j = 0; j < 3; j++) begin
      e1[j] = v[6 + j] - v[j];
      e2[j] = v[3 + j] - v[j];
    end
    len_sq = '0;
    for (j = 0; j < 3; j++) begin
      k1 = (j + 1) % 3;
      k2 = (j + 2) % 3;
      cr[j] = e1[k1] * e2[k2] - e1[k2] * e2[k1];
      mag   = (cr[j] < 0) ? 256'(-cr[j]) : 256'(cr[j]);
      sq[j] = mag * mag;
      len_sq += sq[j];
    end
    degen = (len_sq == 0);
    // Each normal component is the largest root with s*(2n-1)^2 <= cr^2 * 2^62.
    for (j = 0; j < 3; j++) begin
      nq = '0;
      if (!degen) begin
        rhs = sq[j] << 62;
        for (b = 30; b >= 0; b--) begin
          cand = nq | (32'd1 << b);
          d    = 256'(cand) * 2 - 1;
          lhs  = len_sq * d * d;
          if (lhs <= rhs) nq = cand;
        end
      end
      cand = (cr[j] < 0) ? nq : -nq;
      case (j)
        0: r.normal_x = cand;
        1: r.normal_y = cand;
        default: r.normal_z = cand;
      endcase
    end
    // Area is the rounded half length, found bit by bit; it saturates by itself.
    area = '0;
    for (b = 63; b >= 0; b--) begin
      acand = area | (64'd1 << b);
      d     = 256'(acand) * 2 - 1;
      if (d * d <= len_sq) area = acand;
    end
    r.area       = area;
    r.degenerate = degen;
    return r;
  endfunction

  // One mismatch: print a line and count it.
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Send one triangle word; the predicted result is queued when it is taken.
  task automatic send_triangle(tcna_in_t t);
    // Each offered cycle is left idle at the current idle rate.
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(triangle_result(t));
  endtask

  function automatic tcna_in_t pack_triangle(int signed c[9]);
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
  endfunction

  // A coordinate picked from extremes, small values or the full range.
  function automatic int signed pick_coord();
    case ($urandom_range(5))
      0: return CoordMax;
      1: return CoordMin;
      2: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      default: return $urandom();
    endcase
  endfunction

  // A random triangle of one of several shapes.
  function automatic tcna_in_t random_triangle();
    int signed c[9];
    int signed dv, k;
    int        j;
    for (j = 0; j < 9; j++) c[j] = $urandom();
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4: for (j = 0; j < 9; j++) c[j] = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
      5: begin
        // Collinear vertices give a degenerate triangle.
        k = $signed($urandom_range(0, 6)) - 3;
        for (j = 0; j < 3; j++) begin
          c[j]     = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
          dv       = $signed($urandom_range(0, 2 ** 16)) - 2 ** 15;
          c[3 + j] = c[j] + dv;
          c[6 + j] = c[j] + k * dv;
        end
      end
      6: for (j = 0; j < 3; j++) c[3 * $urandom_range(1, 2) + j] = c[j];
      7: begin
        // Triangle in a plane of constant coordinate: the normal is an axis.
        j = $urandom_range(2);
        c[3 + j] = c[j];
        c[6 + j] = c[j];
      end
      default: for (j = 0; j < 9; j++) c[j] = pick_coord();
    endcase
    return pack_triangle(c);
  endfunction

  // Degenerate shapes: a point, a repeated vertex, a straight line.
  task automatic test_degenerate();
    send_triangle(pack_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_triangle(pack_triangle('{CoordMax, CoordMin, 5, CoordMax, CoordMin, 5, 1, 2, 3}));
    send_triangle(pack_triangle('{1, 2, 3, 4, 6, 8, 7, 10, 13}));
    send_triangle(pack_triangle('{CoordMin, CoordMin, CoordMin, 0, 0, 0,
                                   CoordMax, CoordMax, CoordMax}));
  endtask

  // Extremes of the fields and the largest possible areas.
  task automatic test_extremes();
    send_triangle(pack_triangle('{CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMin,
                                   CoordMin, CoordMin, CoordMax}));
    send_triangle(pack_triangle('{CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMax,
                                   CoordMax, CoordMax, CoordMin}));
    send_triangle(pack_triangle('{CoordMin, CoordMin, CoordMin, CoordMax, CoordMin, CoordMin,
                                   CoordMin, CoordMax, CoordMin}));
    send_triangle(pack_triangle('{CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                                   CoordMax, CoordMax, CoordMax}));
    send_triangle(pack_triangle('{-1, -1, -1, 0, -1, -1, -1, 0, -1}));
    send_triangle(pack_triangle('{CoordMax, 0, CoordMin, CoordMin, CoordMax, 0,
                                   0, CoordMin, CoordMax}));
  endtask

  // Small and axis-aligned triangles: exact normals, tiny areas, rounding.
  task automatic test_small_shapes();
    send_triangle(pack_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_triangle(pack_triangle('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
    send_triangle(pack_triangle('{0, 0, 0, 0, 0, 1, 0, 1, 0}));
    send_triangle(pack_triangle('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
    send_triangle(pack_triangle('{0, 0, 0, 1, 1, 0, 0, 1, 1}));
    send_triangle(pack_triangle('{3, -2, 7, 4, -2, 7, 3, -1, 8}));
    send_triangle(pack_triangle('{32'sh01000000, 0, 0, 0, 32'sh01000000, 0,
                                   0, 0, 32'sh01000000}));
    send_triangle(pack_triangle('{-5, -5, -5, -3, -4, -4, -4, -3, -4}));
    send_triangle(pack_triangle('{1, 1, 1, 2, 2, 1, -1, 2, 1}));
  endtask

  // Random triangles under the current idle and stall rates.
  task automatic test_random(int idle_pct, int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    repeat (RandItems) send_triangle(random_triangle());
  endtask

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    tcna_out_t got, want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: nothing accepted for %0d cycles", StallLimit);
        $display("triangle_center_normal_area_tb: FAIL");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_results.size() == 0) begin
          $display("unexpected result word at %0t", $realtime);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.center_x != want.center_x)
            report_mismatch("center_x", got.center_x, want.center_x);
          if (got.center_y != want.center_y)
            report_mismatch("center_y", got.center_y, want.center_y);
          if (got.center_z != want.center_z)
            report_mismatch("center_z", got.center_z, want.center_z);
          if (got.normal_x != want.normal_x)
            report_mismatch("normal_x", got.normal_x, want.normal_x);
          if (got.normal_y != want.normal_y)
            report_mismatch("normal_y", got.normal_y, want.normal_y);
          if (got.normal_z != want.normal_z)
            report_mismatch("normal_z", got.normal_z, want.normal_z);
          if (got.area != want.area)
            report_mismatch("area", got.area, want.area);
          if (got.degenerate != want.degenerate)
            report_mismatch("degenerate", got.degenerate, want.degenerate);
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate();
    test_extremes();
    test_small_shapes();
    test_random(23, 74);
    test_random(74, 23);
    test_random(0, 0);
    in_if.valid <= 1'b0;

    // Drain, then give late extra words time to show up.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
    if (error_count == 0) begin
      $display("triangle_center_normal_area_tb: PASS");
    end else begin
      $display("triangle_center_normal_area_tb: FAIL");
    end
    $finish;
  end

endmodule
